FILE: rtl/auq_pkg.sv
package auq_pkg;

	// Field widths of the descriptor and of the result.
	localparam int unsigned TAG_W   = 16;
	localparam int unsigned SIZE_W  = 20;
	localparam int unsigned NS_W    = 64;
	localparam int unsigned STAMP_W = 48;
	localparam int unsigned DUR_W   = 17;
	localparam int unsigned CNT_W   = 32;
	localparam int unsigned STAT_W  = 3;

	// Stream port widths, padded to whole bytes.
	localparam int unsigned IN_TDATA_W  = 104;
	localparam int unsigned IN_TUSER_W  = 3;
	localparam int unsigned OUT_TDATA_W = 152;
	localparam int unsigned OUT_TUSER_W = 4;

	// Configuration port.
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 17;

	localparam logic [STAMP_W-1:0] STAMP_MAX = '1;
	localparam logic [CNT_W-1:0]   CNT_MAX   = '1;

	// Time base conversion. Nearest rounding of rel * 90000 / 1e9 reduces to
	// floor((rel * 9 + 50000) / 100000), and 100000 = 32 * 3125.
	localparam logic [63:0] TICKS_PER_S = 64'd90000;
	localparam logic [63:0] NS_PER_S    = 64'd1000000000;
	localparam logic [63:0] TICK_GCD    = 64'd10000;
	localparam logic [63:0] NS_MUL      = TICKS_PER_S / TICK_GCD;
	localparam logic [63:0] NS_DIV      = NS_PER_S / TICK_GCD;
	localparam logic [63:0] ROUND_ADD   = NS_DIV / 64'd2;
	localparam int unsigned DIV_SHIFT   = 5;
	localparam logic [63:0] DIV_K       = NS_DIV >> DIV_SHIFT;
	localparam int unsigned REM_W       = 12;
	localparam int unsigned SCALED_W    = 68;
	localparam int unsigned QUOT_W      = SCALED_W - DIV_SHIFT;

	// Division by the odd factor as a multiplication. With 2^REM_W >= DIV_K and
	// RECIP = ceil(2^RECIP_SHIFT / DIV_K), the top bits of x * RECIP give the
	// exact quotient for every QUOT_W-bit x.
	localparam int unsigned RECIP_SHIFT = QUOT_W + REM_W;
	localparam int unsigned PROD_W      = 128;
	localparam logic [PROD_W-1:0] RECIP_WIDE =
		((PROD_W'(1) << RECIP_SHIFT) + PROD_W'(DIV_K) - PROD_W'(1)) / PROD_W'(DIV_K);
	localparam logic [63:0] RECIP = RECIP_WIDE[63:0];

	// One audio frame of 1024 samples at 48 kHz, in 90 kHz ticks.
	localparam logic [63:0] AUDIO_NS = (64'd1024 * NS_PER_S) / 64'd48000;
	localparam logic [63:0] AUDIO_TICKS =
		(AUDIO_NS * TICKS_PER_S + NS_PER_S / 64'd2) / NS_PER_S;
	localparam logic [DUR_W-1:0] AUDIO_DUR = AUDIO_TICKS[DUR_W-1:0];

	localparam logic [DUR_W-1:0] VIDEO_DUR_RST = 17'd1500;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_AUDIO_EN  = 1'b0,
		REG_VIDEO_DUR = 1'b1
	} cfg_reg_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_QUEUED  = 3'd0,
		STAT_DROPPED = 3'd1,
		STAT_ERROR   = 3'd2,
		STAT_POPPED  = 3'd3,
		STAT_EMPTY   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_START,
		S_DIV,
		S_COMMIT
	} fsm_t;

	typedef struct packed {
		logic [TAG_W-1:0]   tag;
		logic [SIZE_W-1:0]  size;
		logic               audio;
		logic               key;
		logic [STAMP_W-1:0] stamp;
		logic [DUR_W-1:0]   dur;
	} entry_t;

	// Broadcast shift controls for the slot chain.
	typedef struct packed {
		logic pop;
		logic evict;
	} slot_ctrl_t;

	typedef struct packed {
		status_t            status;
		logic               ev_valid;
		logic [TAG_W-1:0]   ev_tag;
		entry_t             entry;
		logic [CNT_W-1:0]   drop_total;
	} result_t;

endpackage

FILE: rtl/auq_slot.sv
module auq_slot (
	input  logic                  clk,
	input  auq_pkg::slot_ctrl_t   ctrl,
	input  logic                  load,
	input  auq_pkg::entry_t       new_entry,
	input  auq_pkg::entry_t       right_entry,
	input  logic                  found_in,
	input  logic [15:0]           evtag_in,
	output auq_pkg::entry_t       entry,
	output logic                  found_out,
	output logic [15:0]           evtag_out
);
	import auq_pkg::*;

	entry_t entry_q;
	logic   is_first;
	logic   shift;

	// The first non-key slot from the head is the eviction victim; it and every
	// slot behind it take their right neighbor's entry to close the gap.
	assign is_first  = !found_in && !entry_q.key;
	assign found_out = found_in || !entry_q.key;
	assign evtag_out = is_first ? entry_q.tag : evtag_in;
	assign shift     = ctrl.pop || (ctrl.evict && found_out);
	assign entry     = entry_q;

	always_ff @(posedge clk) begin
		if (load) begin
			entry_q <= new_entry;
		end else if (shift) begin
			entry_q <= right_entry;
		end
	end

endmodule

FILE: rtl/auq_tick_div.sv
module auq_tick_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] rel,
	output logic        done,
	output logic [47:0] ticks
);
	import auq_pkg::*;

	localparam int unsigned QUOT_HI_W = PROD_W - RECIP_SHIFT;

	logic [SCALED_W-1:0]  scaled;
	logic [QUOT_W-1:0]    x_q;
	logic [PROD_W-1:0]    acc_q;
	logic [1:0]           step_q;
	logic                 busy_q;
	logic                 done_q;
	logic [31:0]          mul_a;
	logic [31:0]          mul_b;
	logic [63:0]          part;
	logic [PROD_W-1:0]    part_sh;
	logic [QUOT_HI_W-1:0] quot;

	assign scaled = SCALED_W'(rel) * SCALED_W'(NS_MUL) + SCALED_W'(ROUND_ADD);

	// The product of the dividend and the reciprocal is built from four 32 by 32
	// bit partial products, one per cycle, each added at its own weight.
	assign mul_a = step_q[1] ? 32'(x_q[QUOT_W-1:32]) : x_q[31:0];
	assign mul_b = step_q[0] ? RECIP[63:32] : RECIP[31:0];
	assign part  = {32'd0, mul_a} * {32'd0, mul_b};

	always_comb begin
		unique case (step_q)
			2'd0: begin
				part_sh = PROD_W'(part);
			end
			2'd1, 2'd2: begin
				part_sh = PROD_W'(part) << 32;
			end
			2'd3: begin
				part_sh = PROD_W'(part) << 64;
			end
			default: begin
				part_sh = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == 2'd3) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= scaled[SCALED_W-1:DIV_SHIFT];
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + part_sh;
		end
	end

	assign quot  = acc_q[PROD_W-1:RECIP_SHIFT];
	assign done  = done_q;
	assign ticks = (|quot[QUOT_HI_W-1:STAMP_W]) ? STAMP_MAX : quot[STAMP_W-1:0];

endmodule

FILE: rtl/access_unit_queue_keyframe_evict_unit.sv
// Access-unit descriptor queue for one video and one audio stream.
// Requests arrive on the s_axis channel, one word per push or pop; every
// accepted word gives exactly one result word on the m_axis channel.
// Configuration (audio enable, video frame duration) is to be written by the user
// through cfg_we/cfg_index/cfg_wdata while the queue is idle; the block does not enforce it.
// Pops, rejected pushes and dropped pushes give their result in the cycle after
// acceptance, and such words can be taken every cycle while results drain.
// A push that is queued gives its result once the time conversion is through:
// the start state launches the conversion, the divider accumulates the four
// 32-bit partial products of a reciprocal multiplication, its done strobe hands
// the ticks over, and the commit state stamps and stores the entry. The next
// word is taken only back in idle after the commit, so a queued push holds the input.
// The queue itself is a chain of RING_DEPTH slots with the oldest entry at
// the head; a pop or an eviction shifts the chain (from the victim on) by one slot.
// Reset empties the queue, clears the time origin, the per-stream stamps and
// the counters, and loads the register defaults (audio on, 1500 ticks).
// The result sits in an output register; while the receiver stalls it holds,
// and no new word is accepted until that result has been taken or is taken
// in the same cycle.
module access_unit_queue_keyframe_evict_unit #(
	parameter int unsigned RING_DEPTH = 48
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// unit_tag, unit_size, capture_ns, zero pad
	input  logic [auq_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
	// req_type, stream_is_audio, key_flag
	input  logic [auq_pkg::IN_TUSER_W-1:0]       s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// evicted_tag, out_tag, out_size, out_is_audio, out_key, out_timestamp,
	// out_duration, drop_total, zero pad
	output logic [auq_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
	// status, evicted_valid
	output logic [auq_pkg::OUT_TUSER_W-1:0]      m_axis_tuser,
	input  logic                                 cfg_we,
	input  logic [auq_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [auq_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
	import auq_pkg::*;

	localparam int unsigned IDX_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int unsigned FILL_W = $clog2(RING_DEPTH + 1);

	fsm_t state_q, state_d;

	logic               audio_en_q;
	logic [DUR_W-1:0]   vdur_q;
	logic [FILL_W-1:0]  fill_q;
	logic [NS_W-1:0]    origin_q;
	logic               origin_set_q;
	logic [STAMP_W-1:0] last_q [2];
	logic [1:0]         last_set_q;
	logic [CNT_W-1:0]   drop_q;
	logic [CNT_W-1:0]   queued_q;

	logic [NS_W-1:0]    rel_q;
	logic               p_aud_q;
	logic               p_key_q;
	logic [TAG_W-1:0]   p_tag_q;
	logic [SIZE_W-1:0]  p_size_q;

	result_t            res_q, res_d;
	logic               m_valid_q;

	logic               in_fire, out_free;
	logic               req_pop, aud, key;
	logic [TAG_W-1:0]   tag;
	logic [SIZE_W-1:0]  size;
	logic [NS_W-1:0]    pts;
	logic               is_empty, is_full;
	logic               push_err, push_drop;
	logic [NS_W-1:0]    origin_eff;
	logic [NS_W:0]      diff;
	logic               any_nonkey;
	logic [TAG_W-1:0]   evict_tag;
	logic               drop_inc;
	logic [CNT_W-1:0]   drop_next;
	logic               load_res;
	logic               div_start, div_done, commit_go;
	logic [STAMP_W-1:0] div_ticks;
	logic [STAMP_W-1:0] last_sel, stamp;
	logic [IDX_W-1:0]   widx;
	slot_ctrl_t         ctrl;
	entry_t             new_entry;

	entry_t             slot_q   [RING_DEPTH];
	logic               found    [RING_DEPTH+1];
	logic [TAG_W-1:0]   evtag    [RING_DEPTH+1];

	// Request decode.
	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_valid_q || m_axis_tready;
	assign req_pop  = s_axis_tuser[0];
	assign aud      = s_axis_tuser[1];
	assign key      = s_axis_tuser[2];
	assign tag      = s_axis_tdata[15:0];
	assign size     = s_axis_tdata[35:16];
	assign pts      = s_axis_tdata[99:36];

	assign is_empty   = (fill_q == '0);
	assign is_full    = (fill_q == FILL_W'(RING_DEPTH));
	assign push_err   = (size == '0) || (aud && !audio_en_q);
	assign origin_eff = origin_set_q ? origin_q : pts;
	assign diff       = {1'b0, pts} - {1'b0, origin_eff};
	assign any_nonkey = found[RING_DEPTH];
	assign evict_tag  = evtag[RING_DEPTH];
	// Audio before the origin is late; a full queue only makes room for a
	// video key frame, and only when some non-key entry is there to evict.
	assign push_drop  = (aud && diff[NS_W]) ||
		(is_full && (aud || !key || !any_nonkey));

	assign drop_inc  = in_fire && !req_pop && !push_err && push_drop;
	assign drop_next = (drop_inc && drop_q != CNT_MAX) ? drop_q + 1'b1 : drop_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire && !req_pop && !push_err && !push_drop) begin
					state_d = S_START;
				end
			end
			S_START: begin
				state_d = S_DIV;
			end
			S_DIV: begin
				if (div_done) begin
					state_d = S_COMMIT;
				end
			end
			S_COMMIT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State outputs.
	always_comb begin
		s_axis_tready = 1'b0;
		div_start     = 1'b0;
		commit_go     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_axis_tready = out_free;
			end
			S_START: begin
				div_start = 1'b1;
			end
			S_DIV: begin
			end
			S_COMMIT: begin
				commit_go = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	auq_tick_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.rel    (rel_q),
		.done   (div_done),
		.ticks  (div_ticks)
	);

	// Per-stream stamps strictly increase, holding at the maximum.
	assign last_sel = p_aud_q ? last_q[1] : last_q[0];
	always_comb begin
		stamp = div_ticks;
		if (last_set_q[p_aud_q] && div_ticks <= last_sel) begin
			stamp = (last_sel == STAMP_MAX) ? STAMP_MAX : last_sel + 1'b1;
		end
	end

	always_comb begin
		new_entry.tag   = p_tag_q;
		new_entry.size  = p_size_q;
		new_entry.audio = p_aud_q;
		new_entry.key   = p_aud_q || p_key_q;
		new_entry.stamp = stamp;
		new_entry.dur   = p_aud_q ? AUDIO_DUR : vdur_q;
	end

	// On eviction the new entry is written to the last slot while the slots behind the victim shift toward the head.
	assign widx       = is_full ? IDX_W'(RING_DEPTH - 1) : fill_q[IDX_W-1:0];
	assign ctrl.pop   = in_fire && req_pop && !is_empty;
	assign ctrl.evict = commit_go && is_full;

	assign found[0] = 1'b0;
	assign evtag[0] = '0;

	for (genvar i = 0; i < RING_DEPTH; i++) begin : g_slot
		entry_t right;
		if (i == RING_DEPTH - 1) begin : g_last
			assign right = '0;
		end else begin : g_mid
			assign right = slot_q[i+1];
		end
		auq_slot u_slot (
			.clk         (clk),
			.ctrl        (ctrl),
			.load        (commit_go && widx == IDX_W'(i)),
			.new_entry   (new_entry),
			.right_entry (right),
			.found_in    (found[i]),
			.evtag_in    (evtag[i]),
			.entry       (slot_q[i]),
			.found_out   (found[i+1]),
			.evtag_out   (evtag[i+1])
		);
	end

	// Configuration and queue bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			audio_en_q   <= 1'b1;
			vdur_q       <= VIDEO_DUR_RST;
			fill_q       <= '0;
			origin_q     <= '0;
			origin_set_q <= 1'b0;
			last_q[0]    <= '0;
			last_q[1]    <= '0;
			last_set_q   <= '0;
			drop_q       <= '0;
			queued_q     <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_AUDIO_EN:  audio_en_q <= cfg_wdata[0];
					REG_VIDEO_DUR: vdur_q     <= cfg_wdata[DUR_W-1:0];
					default: begin
					end
				endcase
			end
			if (in_fire && !req_pop && !push_err && !origin_set_q) begin
				origin_q     <= pts;
				origin_set_q <= 1'b1;
			end
			drop_q <= drop_next;
			if (ctrl.pop) begin
				fill_q <= fill_q - 1'b1;
			end else if (commit_go && !is_full) begin
				fill_q <= fill_q + 1'b1;
			end
			if (commit_go) begin
				last_q[p_aud_q]     <= stamp;
				last_set_q[p_aud_q] <= 1'b1;
				if (queued_q != CNT_MAX) begin
					queued_q <= queued_q + 1'b1;
				end
			end
		end
	end

	// Pending push, held while the stamp is computed.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			rel_q    <= diff[NS_W] ? '0 : diff[NS_W-1:0];
			p_aud_q  <= aud;
			p_key_q  <= key;
			p_tag_q  <= tag;
			p_size_q <= size;
		end
	end

	// Result word.
	always_comb begin
		res_d            = '0;
		res_d.drop_total = drop_next;
		if (state_q == S_COMMIT) begin
			res_d.status   = STAT_QUEUED;
			res_d.ev_valid = is_full;
			res_d.ev_tag   = is_full ? evict_tag : '0;
		end else if (req_pop) begin
			if (is_empty) begin
				res_d.status = STAT_EMPTY;
			end else begin
				res_d.status = STAT_POPPED;
				res_d.entry  = slot_q[0];
			end
		end else if (push_err) begin
			res_d.status = STAT_ERROR;
		end else begin
			res_d.status = STAT_DROPPED;
		end
	end

	assign load_res = (in_fire && (req_pop || push_err || push_drop)) || commit_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (load_res) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			res_q <= res_d;
		end
	end

	assign m_axis_tvalid          = m_valid_q;
	assign m_axis_tuser[2:0]      = res_q.status;
	assign m_axis_tuser[3]        = res_q.ev_valid;
	assign m_axis_tdata[15:0]     = res_q.ev_tag;
	assign m_axis_tdata[31:16]    = res_q.entry.tag;
	assign m_axis_tdata[51:32]    = res_q.entry.size;
	assign m_axis_tdata[52]       = res_q.entry.audio;
	assign m_axis_tdata[53]       = res_q.entry.key;
	assign m_axis_tdata[101:54]   = res_q.entry.stamp;
	assign m_axis_tdata[118:102]  = res_q.entry.dur;
	assign m_axis_tdata[150:119]  = res_q.drop_total;
	assign m_axis_tdata[151]      = 1'b0;

endmodule

FILE: sim/auq_checker.sv
module auq_checker #(
	parameter int unsigned SLOTS = 48
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	input  logic                             s_axis_tready,
	// unit_tag, unit_size, capture_ns, zero pad
	input  logic [auq_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	// req_type, stream_is_audio, key_flag
	input  logic [auq_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
	input  logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// evicted_tag, out_tag, out_size, out_is_audio, out_key, out_timestamp,
	// out_duration, drop_total, zero pad
	input  logic [auq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	// status, evicted_valid
	input  logic [auq_pkg::OUT_TUSER_W-1:0]  m_axis_tuser,
	input  logic                             cfg_we,
	input  logic [auq_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [auq_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output int unsigned                      mismatch_count,
	output int unsigned                      results_outstanding
);
	import auq_pkg::*;

	// 1024 samples at 48 kHz, rounded to the nearest 90 kHz tick.
	localparam logic [DUR_W-1:0] AUDIO_FRAME_TICKS = 17'd1920;
	localparam logic [63:0] STAMP_LIMIT = {16'd0, STAMP_MAX};
	localparam int unsigned PRINT_CAP = 100;

	typedef struct packed {
		logic [TAG_W-1:0]   tag;
		logic [SIZE_W-1:0]  size;
		logic               audio;
		logic               key;
		logic [STAMP_W-1:0] stamp;
		logic [DUR_W-1:0]   dur;
	} unit_desc_t;

	typedef struct packed {
		status_t            status;
		logic               ev_valid;
		logic [TAG_W-1:0]   ev_tag;
		unit_desc_t         unit;
		logic [CNT_W-1:0]   drops;
	} unit_result_t;

	unit_desc_t         queued_units[$];
	unit_result_t       awaited_results[$];
	logic [63:0]        origin;
	logic               origin_known;
	logic [STAMP_W-1:0] last_stamp_of[2];
	logic               stamp_seen[2];
	logic [CNT_W-1:0]   drop_tally;
	logic               audio_on;
	logic [DUR_W-1:0]   video_ticks;
	int unsigned        result_index;

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (mismatch_count < PRINT_CAP)
			$display("[%0t] result %0d: %s got 0x%0h, expected 0x%0h",
				$time, result_index, what, got, want);
		mismatch_count++;
	endtask

	task automatic check_field(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	// Nearest rounding of rel * 90000 / 1e9, split in whole seconds and a
	// remainder so that nothing overflows 64 bits.
	function automatic logic [STAMP_W-1:0] ns_to_90k(input logic [63:0] rel);
		logic [63:0] secs;
		logic [63:0] rest;
		logic [63:0] part;
		logic [63:0] ticks;
		secs = rel / NS_PER_S;
		rest = rel % NS_PER_S;
		part = (rest * TICKS_PER_S + NS_PER_S / 64'd2) / NS_PER_S;
		if (secs > STAMP_LIMIT / TICKS_PER_S)
			return STAMP_MAX;
		ticks = secs * TICKS_PER_S + part;
		return (ticks > STAMP_LIMIT) ? STAMP_MAX : ticks[STAMP_W-1:0];
	endfunction

	function automatic unit_result_t queue_outcome(input logic [IN_TUSER_W-1:0] user,
			input logic [IN_TDATA_W-1:0] data);
		unit_result_t       res;
		unit_desc_t         u;
		logic               aud;
		logic               key;
		logic [63:0]        ns;
		logic [63:0]        rel;
		logic [STAMP_W-1:0] ts;
		int                 victim;
		res = '0;
		u = '0;
		aud = user[1];
		key = user[2];
		u.tag = data[15:0];
		u.size = data[35:16];
		ns = data[99:36];
		victim = -1;
		if (user[0]) begin
			if (queued_units.size() == 0) begin
				res.status = STAT_EMPTY;
			end else begin
				res.status = STAT_POPPED;
				res.unit = queued_units.pop_front();
			end
		end else if (u.size == '0 || (aud && !audio_on)) begin
			res.status = STAT_ERROR;
		end else begin
			if (!origin_known) begin
				origin = ns;
				origin_known = 1'b1;
			end
			// Only a video key frame may push out the oldest non-key word.
			if (queued_units.size() >= SLOTS && !aud && key) begin
				for (int i = 0; i < queued_units.size() && victim < 0; i++)
					if (!queued_units[i].key)
						victim = i;
			end
			if ((aud && ns < origin) || (queued_units.size() >= SLOTS && victim < 0)) begin
				if (drop_tally != CNT_MAX)
					drop_tally++;
				res.status = STAT_DROPPED;
			end else begin
				if (victim >= 0) begin
					res.ev_valid = 1'b1;
					res.ev_tag = queued_units[victim].tag;
					queued_units.delete(victim);
				end
				rel = (ns > origin) ? ns - origin : 64'd0;
				ts = ns_to_90k(rel);
				if (stamp_seen[aud] && ts <= last_stamp_of[aud])
					ts = (last_stamp_of[aud] != STAMP_MAX) ? last_stamp_of[aud] + 1'b1 : STAMP_MAX;
				last_stamp_of[aud] = ts;
				stamp_seen[aud] = 1'b1;
				u.audio = aud;
				u.key = aud | key;
				u.stamp = ts;
				u.dur = aud ? AUDIO_FRAME_TICKS : video_ticks;
				queued_units.push_back(u);
				res.status = STAT_QUEUED;
			end
		end
		res.drops = drop_tally;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		unit_result_t want;
		if (!arst_n) begin
			queued_units.delete();
			awaited_results.delete();
			origin = '0;
			origin_known = 1'b0;
			last_stamp_of[0] = '0;
			last_stamp_of[1] = '0;
			stamp_seen[0] = 1'b0;
			stamp_seen[1] = 1'b0;
			drop_tally = '0;
			audio_on = 1'b1;
			video_ticks = VIDEO_DUR_RST;
			mismatch_count = 0;
			result_index = 0;
			results_outstanding <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (awaited_results.size() == 0) begin
					report_mismatch("word with no request waiting, tuser", m_axis_tuser, '0);
				end else begin
					want = awaited_results.pop_front();
					check_field("status", m_axis_tuser[2:0], want.status);
					check_field("evicted_valid", m_axis_tuser[3], want.ev_valid);
					check_field("evicted_tag", m_axis_tdata[15:0], want.ev_tag);
					check_field("out_tag", m_axis_tdata[31:16], want.unit.tag);
					check_field("out_size", m_axis_tdata[51:32], want.unit.size);
					check_field("out_is_audio", m_axis_tdata[52], want.unit.audio);
					check_field("out_key", m_axis_tdata[53], want.unit.key);
					check_field("out_timestamp", m_axis_tdata[101:54], want.unit.stamp);
					check_field("out_duration", m_axis_tdata[118:102], want.unit.dur);
					check_field("drop_total", m_axis_tdata[150:119], want.drops);
				end
				result_index++;
			end
			if (s_axis_tvalid && s_axis_tready)
				awaited_results.push_back(queue_outcome(s_axis_tuser, s_axis_tdata));
			if (cfg_we) begin
				case (cfg_index)
					REG_AUDIO_EN: begin
						audio_on = cfg_wdata[0];
					end
					REG_VIDEO_DUR: begin
						video_ticks = cfg_wdata[DUR_W-1:0];
					end
					default: begin
					end
				endcase
			end
			results_outstanding <= awaited_results.size();
		end
	end

endmodule

FILE: sim/tb_top.sv
module tb_top;
	import auq_pkg::*;

	localparam int unsigned RING_SLOTS = 48;
	// Quiet cycles after the last result, well above what a queued push takes.
	localparam int unsigned SETTLE_CYCLES = 80;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned PHASES = 9;
	localparam int unsigned PHASE_WORDS = 65;
	localparam logic [63:0] ORIGIN_NS = 64'd5000000000;
	// Largest whole second count that still fits a 48-bit tick stamp.
	localparam logic [63:0] LAST_FULL_SECOND = 64'd3127499741 * 64'd1000000000;

	logic                    clk;
	logic                    arst_n;
	logic                    s_axis_tvalid;
	logic                    s_axis_tready;
	logic [IN_TDATA_W-1:0]   s_axis_tdata;
	logic [IN_TUSER_W-1:0]   s_axis_tuser;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready;
	logic [OUT_TDATA_W-1:0]  m_axis_tdata;
	logic [OUT_TUSER_W-1:0]  m_axis_tuser;
	logic                    cfg_we;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_wdata;
	int unsigned             mismatch_total;
	int unsigned             results_left;
	int unsigned             cycle_count = 0;
	logic                    tx_calm;
	logic                    rx_calm;
	logic [63:0]             stream_clock;
	logic [63:0]             prev_capture;

	access_unit_queue_keyframe_evict_unit #(
		.RING_DEPTH(RING_SLOTS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	auq_checker #(
		.SLOTS(RING_SLOTS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.mismatch_count(mismatch_total),
		.results_outstanding(results_left)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Result side: a random stall before each word, none while rx_calm is set.
	initial begin
		int unsigned gap;
		forever begin
			gap = rx_calm ? 0 : $urandom_range(0, 5);
			if (gap != 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
		end
	end

	// tvalid stays high after acceptance when the next word follows at once.
	task automatic send_word(input logic [IN_TUSER_W-1:0] user,
			input logic [IN_TDATA_W-1:0] data);
		int unsigned gap;
		gap = tx_calm ? 0 : $urandom_range(0, 5);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= user;
		s_axis_tdata <= data;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic push_unit(input logic aud, input logic key, input logic [TAG_W-1:0] tag,
			input logic [SIZE_W-1:0] size, input logic [63:0] ns);
		prev_capture = ns;
		send_word({key, aud, 1'b0}, {4'd0, ns, size, tag});
	endtask

	// Stream and key bits and the data of a pop carry noise.
	task automatic pop_unit();
		logic [IN_TDATA_W-1:0] junk;
		junk = IN_TDATA_W'({$urandom, $urandom, $urandom, $urandom});
		send_word({$urandom_range(0, 3) == 0 ? 2'b11 : 2'($urandom), 1'b1}, junk);
	endtask

	task automatic settle_queue();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (results_left != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic audio_en, input logic [DUR_W-1:0] video_dur);
		cfg_we <= 1'b1;
		cfg_index <= REG_AUDIO_EN;
		cfg_wdata <= {16'd0, audio_en};
		@(posedge clk);
		cfg_index <= REG_VIDEO_DUR;
		cfg_wdata <= video_dur;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_push(input int unsigned key_pct, input int unsigned audio_pct);
		logic              aud;
		logic              key;
		logic [SIZE_W-1:0] size;
		logic [63:0]       ns;
		int unsigned       pick;
		aud = $urandom_range(0, 99) < audio_pct;
		key = $urandom_range(0, 99) < key_pct;
		size = ($urandom_range(0, 99) < 3) ? '0 : SIZE_W'($urandom_range(1, 20'hFFFFF));
		pick = $urandom_range(0, 99);
		stream_clock += 64'($urandom_range(0, 40000000));
		if (pick < 5)
			ns = ORIGIN_NS - 64'($urandom_range(1, 1000000000));
		else if (pick < 10)
			ns = prev_capture;
		else if (pick < 12) begin
			stream_clock += 64'($urandom) * 64'd1000;
			ns = ORIGIN_NS + stream_clock;
		end else
			ns = ORIGIN_NS + stream_clock;
		push_unit(aud, key, TAG_W'($urandom), size, ns);
	endtask

	task automatic run_phase(input int unsigned push_pct, input int unsigned key_pct,
			input int unsigned audio_pct);
		for (int unsigned i = 0; i < PHASE_WORDS; i++) begin
			if ($urandom_range(0, 99) < push_pct)
				random_push(key_pct, audio_pct);
			else
				pop_unit();
		end
	endtask

	initial begin
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		cfg_we = 1'b0;
		cfg_index = REG_AUDIO_EN;
		cfg_wdata = '0;
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		stream_clock = 64'd3000000000;
		prev_capture = ORIGIN_NS;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Audio off: error cases come before the time origin is set.
		set_config(1'b0, 17'd90000);
		pop_unit();
		push_unit(1'b0, 1'b0, 16'h0001, '0, ORIGIN_NS);
		push_unit(1'b1, 1'b1, 16'h0002, 20'd5, ORIGIN_NS);
		push_unit(1'b0, 1'b1, 16'hFFFF, 20'hFFFFF, ORIGIN_NS);
		settle_queue();

		// Rounding at half a tick, per-stream clamping and audio before origin.
		set_config(1'b1, 17'd1);
		push_unit(1'b1, 1'b0, 16'h1111, 20'd100, ORIGIN_NS - 64'd1);
		push_unit(1'b1, 1'b0, 16'h0000, 20'd200, ORIGIN_NS);
		push_unit(1'b0, 1'b0, 16'h2222, 20'd300, ORIGIN_NS + 64'd49999);
		push_unit(1'b0, 1'b0, 16'h3333, 20'd400, ORIGIN_NS + 64'd50000);
		push_unit(1'b0, 1'b1, 16'h4444, 20'd500, ORIGIN_NS + 64'd61111);
		push_unit(1'b1, 1'b0, 16'h5555, 20'd600, ORIGIN_NS + 64'd50000);
		push_unit(1'b1, 1'b1, 16'h6666, 20'd700, ORIGIN_NS + 64'd50000);
		push_unit(1'b0, 1'b0, 16'h7777, 20'd800, 64'd0);
		push_unit(1'b0, 1'b1, 16'h0000, 20'd1, ORIGIN_NS + 64'd2000000000);
		repeat (10) pop_unit();
		settle_queue();

		for (int unsigned p = 0; p < PHASES; p++) begin
			tx_calm = (p % 3 == 1) || ($urandom_range(0, 7) == 0);
			rx_calm = (p % 4 == 2) || ($urandom_range(0, 7) == 0);
			case (p)
				0: begin
					set_config(1'b1, 17'd1);
					run_phase(95, 30, 20);
				end
				1: begin
					set_config(1'b1, 17'd90000);
					run_phase(50, 50, 30);
				end
				2: begin
					// All key words: a full queue soon has nothing left to evict.
					set_config(1'b1, 17'd1500);
					run_phase(95, 100, 50);
				end
				3: begin
					set_config(1'b0, 17'h1FFFF);
					run_phase(15, 50, 30);
				end
				4: begin
					set_config(1'b0, 17'd0);
					run_phase(90, 20, 40);
				end
				default: begin
					set_config(1'($urandom), 17'($urandom_range(1, 90000)));
					run_phase($urandom_range(20, 95), $urandom_range(0, 100),
						$urandom_range(0, 60));
				end
			endcase
			settle_queue();
		end

		// Stamp saturation last, since a stream stays at the top once there.
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		set_config(1'b1, 17'd1500);
		repeat (50) pop_unit();
		push_unit(1'b1, 1'b0, 16'hA001, 20'd10, ORIGIN_NS + LAST_FULL_SECOND + 64'd229400000);
		push_unit(1'b0, 1'b1, 16'hA002, 20'd20, ORIGIN_NS + LAST_FULL_SECOND + 64'd229500000);
		push_unit(1'b1, 1'b0, 16'hA003, 20'd30, ORIGIN_NS + LAST_FULL_SECOND + 64'd229600000);
		push_unit(1'b0, 1'b0, 16'hA004, 20'd40, 64'hFFFF_FFFF_FFFF_FFFF);
		push_unit(1'b1, 1'b0, 16'hA005, 20'd50, 64'h8000_0000_0000_0000);
		repeat (6) pop_unit();
		settle_queue();

		if (mismatch_total == 0 && results_left == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
